FILE: hw/rtl/bwma_pkg.sv
// ---------------------------------------------------------------------------
// bwma_pkg
// Types and constants shared by the binned weighted mean accumulator.
// ---------------------------------------------------------------------------
`default_nettype none
package bwma_pkg;

	localparam int BIN_DEPTH_DEF = 64;
	localparam int CFG_W        = 7;
	localparam logic [CFG_W-1:0] BINS_RESET = 7'd64;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_NORM   = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [62:0] ONE_Q16 = 63'd65536;
	localparam logic [62:0] W_MAX   = {63{1'b1}};
	localparam int DIV_STEPS = 80;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         bin_index;
		logic [30:0]        pair_weight;
		logic signed [31:0] parallel_sep;
		logic signed [31:0] perpendicular_sep;
		logic signed [31:0] redshift;
	} in_item_t;

	typedef struct packed {
		logic               index_ok;
		logic signed [63:0] pi_value;
		logic signed [63:0] sigma_value;
		logic signed [63:0] z_value;
		logic [62:0]        weight_value;
		logic [6:0]         zero_weight_bins;
	} out_item_t;

	typedef struct packed {
		logic signed [63:0] pi;
		logic signed [63:0] sigma;
		logic signed [63:0] z;
		logic [62:0]        w;
	} bin_rec_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_MUL,
		ST_ADD_WR,
		ST_RD_OUT,
		ST_NRM_RD,
		ST_NRM_CHK,
		ST_NRM_DIV,
		ST_NRM_WR,
		ST_NRM_OUT
	} state_t;

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_add64 = s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add64 = s[63:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bwma_ram.sv
// ---------------------------------------------------------------------------
// bwma_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module bwma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bwma_div.sv
// ---------------------------------------------------------------------------
// bwma_div
// Radix-2 restoring divider: trunc(s * 2^16 / w), saturated to 64 bits.
// ---------------------------------------------------------------------------
`default_nettype none
module bwma_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] dividend,
	input  wire logic [62:0]        divisor,
	output logic                    busy,
	output logic signed [63:0]      quotient
);
	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [79:0] num_q;
	logic [62:0] rem_q;
	logic [79:0] quo_q;
	logic [62:0] div_q;

	logic [63:0] rem_sh;
	logic        ge;
	logic [63:0] limit;
	logic [63:0] qc;

	assign rem_sh = {rem_q, num_q[79]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign limit  = {neg_q, {63{~neg_q}}};
	assign qc     = (quo_q > {16'd0, limit}) ? limit : quo_q[63:0];
	assign quotient = neg_q ? -qc : qc;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(bwma_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			num_q <= {(dividend[63] ? -dividend : dividend), 16'd0};
			rem_q <= '0;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[78:0], 1'b0};
			rem_q <= ge ? 63'(rem_sh - {1'b0, div_q}) : rem_sh[62:0];
			quo_q <= {quo_q[78:0], ge};
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/binned_weighted_mean_accumulator_core.sv
// ---------------------------------------------------------------------------
// binned_weighted_mean_accumulator_core
// Per-bin weighted sums in one bin RAM, with add, normalize and read requests.
// ---------------------------------------------------------------------------
// After reset the bin RAM is cleared one entry a cycle, and in_ready stays
// low meanwhile. Requests run one at a time: an add reads the RAM, multiplies
// and does a saturating write-back; a read reads the RAM and then waits on
// out_ready while a result is held. A normalize walks the active bins; a bin
// with weight zero or exactly 1.0 is read and left as it is, any other bin is
// read, divided by the 80-step bit-serial divider (three lanes in parallel) and written.
`default_nettype none
module binned_weighted_mean_accumulator_core #(
	parameter int BIN_DEPTH = bwma_pkg::BIN_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bwma_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bwma_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [6:0]          cfg_wdata
);
	localparam int AW  = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
	localparam int CAP = (BIN_DEPTH > 127) ? 127 : BIN_DEPTH;
	localparam int RW  = $bits(bwma_pkg::bin_rec_t);

	bwma_pkg::state_t state_q, state_d;

	logic [6:0]    bins_q;
	logic [6:0]    act;
	logic [AW-1:0] clr_q;
	logic [6:0]    idx_q;
	logic [6:0]    zeros_q;
	logic          rd_ok_q;
	bwma_pkg::in_item_t item_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	bwma_pkg::bin_rec_t ram_wdata, ram_rdata;
	logic [RW-1:0] rdata_raw;

	logic signed [63:0] p_pi_s1, p_sg_s1, p_z_s1;
	bwma_pkg::bin_rec_t rec_s1;

	logic          div_start;
	logic [2:0]    div_busy;
	logic signed [63:0] q_pi, q_sg, q_z;

	logic          in_acc;
	logic          out_free;
	logic          idx_in_range;
	logic          last_bin;
	logic [AW+6:0] in_addr_w, i_addr_w;
	logic [62:0]   w_sum;
	logic [63:0]   w_add;

	assign act      = (bins_q < 7'(CAP)) ? bins_q : 7'(CAP);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign idx_in_range = {1'b0, in_data.bin_index} < act;
	assign last_bin = (idx_q + 7'd1) == act;
	assign in_addr_w = {{(AW + 1){1'b0}}, in_data.bin_index};
	assign i_addr_w  = {{AW{1'b0}}, idx_q};
	assign ram_rdata = bwma_pkg::bin_rec_t'(rdata_raw);
	assign w_add = {1'b0, rec_s1.w} + {33'd0, item_q.pair_weight};
	assign w_sum = w_add[63] ? bwma_pkg::W_MAX : w_add[62:0];

	bwma_ram #(.WIDTH(RW), .DEPTH(BIN_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (RW'(ram_wdata)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata_raw)
	);

	bwma_div u_div_pi (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(ram_rdata.pi),
		.divisor(ram_rdata.w), .busy(div_busy[0]), .quotient(q_pi)
	);
	bwma_div u_div_sg (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(ram_rdata.sigma),
		.divisor(ram_rdata.w), .busy(div_busy[1]), .quotient(q_sg)
	);
	bwma_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(ram_rdata.z),
		.divisor(ram_rdata.w), .busy(div_busy[2]), .quotient(q_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bwma_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = i_addr_w[AW-1:0];
		ram_raddr = i_addr_w[AW-1:0];
		ram_wdata = '0;
		div_start = 1'b0;
		case (state_q)
			bwma_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(BIN_DEPTH - 1)) begin
					state_d = bwma_pkg::ST_IDLE;
				end
			end
			bwma_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = in_addr_w[AW-1:0];
				if (in_valid) begin
					case (in_data.kind)
						bwma_pkg::KIND_ADD: begin
							if (idx_in_range) begin
								ram_re  = 1'b1;
								state_d = bwma_pkg::ST_ADD_MUL;
							end
						end
						bwma_pkg::KIND_READ: begin
							ram_re  = idx_in_range;
							state_d = bwma_pkg::ST_RD_OUT;
						end
						bwma_pkg::KIND_NORM: begin
							state_d = (act == '0) ? bwma_pkg::ST_NRM_OUT
								: bwma_pkg::ST_NRM_RD;
						end
						default: begin
							state_d = bwma_pkg::ST_IDLE;
						end
					endcase
				end
			end
			bwma_pkg::ST_ADD_MUL: begin
				state_d = bwma_pkg::ST_ADD_WR;
			end
			bwma_pkg::ST_ADD_WR: begin
				ram_we          = 1'b1;
				ram_waddr       = i_addr_w[AW-1:0];
				ram_wdata.pi    = bwma_pkg::sat_add64(rec_s1.pi, p_pi_s1);
				ram_wdata.sigma = bwma_pkg::sat_add64(rec_s1.sigma, p_sg_s1);
				ram_wdata.z     = bwma_pkg::sat_add64(rec_s1.z, p_z_s1);
				ram_wdata.w     = w_sum;
				state_d         = bwma_pkg::ST_IDLE;
			end
			bwma_pkg::ST_RD_OUT: begin
				if (out_free) begin
					state_d = bwma_pkg::ST_IDLE;
				end
			end
			bwma_pkg::ST_NRM_RD: begin
				ram_re  = 1'b1;
				state_d = bwma_pkg::ST_NRM_CHK;
			end
			bwma_pkg::ST_NRM_CHK: begin
				if (ram_rdata.w == '0 || ram_rdata.w == bwma_pkg::ONE_Q16) begin
					state_d = last_bin ? bwma_pkg::ST_NRM_OUT : bwma_pkg::ST_NRM_RD;
				end else begin
					div_start = 1'b1;
					state_d   = bwma_pkg::ST_NRM_DIV;
				end
			end
			bwma_pkg::ST_NRM_DIV: begin
				if (div_busy == '0) begin
					state_d = bwma_pkg::ST_NRM_WR;
				end
			end
			bwma_pkg::ST_NRM_WR: begin
				ram_we          = 1'b1;
				ram_wdata.pi    = q_pi;
				ram_wdata.sigma = q_sg;
				ram_wdata.z     = q_z;
				ram_wdata.w     = bwma_pkg::ONE_Q16;
				state_d = last_bin ? bwma_pkg::ST_NRM_OUT : bwma_pkg::ST_NRM_RD;
			end
			bwma_pkg::ST_NRM_OUT: begin
				if (out_free) begin
					state_d = bwma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bwma_pkg::ST_IDLE;
			end
		endcase
	end

	// control counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q    <= bwma_pkg::BINS_RESET;
			clr_q     <= '0;
			idx_q     <= '0;
			zeros_q   <= '0;
			rd_ok_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				bins_q <= cfg_wdata;
			end
			if (state_q == bwma_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (in_acc) begin
				idx_q   <= in_data.kind == bwma_pkg::KIND_NORM ? 7'd0
					: {1'b0, in_data.bin_index};
				zeros_q <= '0;
				rd_ok_q <= idx_in_range;
			end
			if (state_q == bwma_pkg::ST_NRM_CHK && ram_rdata.w == '0) begin
				zeros_q <= zeros_q + 7'd1;
			end
			// advance to the next bin after a skip or a write-back
			if ((state_q == bwma_pkg::ST_NRM_CHK && state_d == bwma_pkg::ST_NRM_RD)
					|| (state_q == bwma_pkg::ST_NRM_WR && !last_bin)) begin
				idx_q <= idx_q + 7'd1;
			end
			if ((state_q == bwma_pkg::ST_RD_OUT || state_q == bwma_pkg::ST_NRM_OUT)
					&& out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == bwma_pkg::ST_ADD_MUL) begin
			rec_s1  <= ram_rdata;
			p_pi_s1 <= item_q.parallel_sep * $signed({1'b0, item_q.pair_weight});
			p_sg_s1 <= item_q.perpendicular_sep * $signed({1'b0, item_q.pair_weight});
			p_z_s1  <= item_q.redshift * $signed({1'b0, item_q.pair_weight});
		end
		if (state_q == bwma_pkg::ST_RD_OUT && out_free) begin
			out_data.index_ok         <= rd_ok_q;
			out_data.pi_value         <= rd_ok_q ? ram_rdata.pi : '0;
			out_data.sigma_value      <= rd_ok_q ? ram_rdata.sigma : '0;
			out_data.z_value          <= rd_ok_q ? ram_rdata.z : '0;
			out_data.weight_value     <= rd_ok_q ? ram_rdata.w : '0;
			out_data.zero_weight_bins <= '0;
		end
		if (state_q == bwma_pkg::ST_NRM_OUT && out_free) begin
			out_data.index_ok         <= 1'b0;
			out_data.pi_value         <= '0;
			out_data.sigma_value      <= '0;
			out_data.z_value          <= '0;
			out_data.weight_value     <= '0;
			out_data.zero_weight_bins <= zeros_q;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bwma_checker.sv
// ---------------------------------------------------------------------------
// bwma_checker
// Port-level checks on the accumulator core, bound to the core module.
// ---------------------------------------------------------------------------
`default_nettype none
module bwma_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire bwma_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire bwma_pkg::out_item_t out_data
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.index_ok |-> out_data.pi_value == '0
			&& out_data.sigma_value == '0 && out_data.z_value == '0
			&& out_data.weight_value == '0)
		else $error("flagged result carries values");

	a_read_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.index_ok |-> out_data.zero_weight_bins == '0)
		else $error("read result carries a zero count");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind == bwma_pkg::KIND_READ |=> !in_ready)
		else $error("ready right after a read request");
endmodule

bind binned_weighted_mean_accumulator_core bwma_checker u_bwma_checker (.*);
`default_nettype wire
